[rtl/tkhq_pkg.sv]
// ----------------------------------------------------------------------------
// tkhq_pkg
// Types, codes and the ranking function for the two-key max-heap queue.
// ----------------------------------------------------------------------------
package tkhq_pkg;

   // default heap depth and capacity register reset value
   localparam int unsigned TKHQ_DEPTH     = 64;
   localparam logic [6:0]  TKHQ_CAP_RESET = 7'd64;

   // request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // register index of the capacity register
   localparam logic CSR_CAPACITY = 1'b0;

   // result status codes
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } tkhq_status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_LAST,
      ST_DN_RD,
      ST_DN_CMP,
      ST_RESP
   } tkhq_state_type;

   // one heap entry
   typedef struct packed {
      logic [7:0]  severity;
      logic [15:0] service_time;
      logic [15:0] tag;
   } tkhq_entry_type;

   // request payload
   typedef struct packed {
      logic        kind;
      logic [7:0]  severity;
      logic [15:0] service_time;
      logic [15:0] tag;
   } tkhq_req_type;

   // result payload
   typedef struct packed {
      logic [1:0]  status;
      logic        is_empty;
      logic [7:0]  top_severity;
      logic [15:0] top_time;
      logic [15:0] top_tag;
      logic [6:0]  entry_count;
   } tkhq_rsp_type;

   // a outranks b: higher severity, then smaller service time
   function automatic logic outranks(input tkhq_entry_type a, input tkhq_entry_type b);
      logic res;
      if (a.severity != b.severity) begin
         res = (a.severity > b.severity);
      end else begin
         res = (a.service_time < b.service_time);
      end
      return res;
   endfunction

endpackage

[rtl/two_key_max_heap_queue.sv]
// ----------------------------------------------------------------------------
// two_key_max_heap_queue
// Rejected steps and removal of the last entry go straight to the result;
// an insert climbs, reading and comparing one parent per level; other removes
// move the last entry to the root and descend, comparing children per level.
// One item at a time: a new request is taken only while busy is low.
// Reset clears count and control, sets capacity to 64; the store is not cleared.
// Results cannot be stalled; the strobe is high for one cycle per item.
// ----------------------------------------------------------------------------
module two_key_max_heap_queue #(
   parameter int unsigned DEPTH = tkhq_pkg::TKHQ_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  tkhq_pkg::tkhq_req_type req_data,
   // result channel
   output logic                  rsp_valid,
   output tkhq_pkg::tkhq_rsp_type rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import tkhq_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned LW = (CW > 7) ? CW : 7;

   // state
   tkhq_state_type  state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   pos_ff, pos_in;
   tkhq_entry_type  move_ff, move_in;
   tkhq_entry_type  top_ff;
   tkhq_status_type status_ff, status_in;
   logic [6:0]      cap_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   tkhq_rsp_type    rsp_data_ff, rsp_data_in;

   // heap memory and its ports
   tkhq_entry_type  heap_mem [DEPTH];
   tkhq_entry_type  rd_a_ff, rd_b_ff;
   logic [AW-1:0]   rd_a_addr, rd_b_addr, wr_addr;
   logic            wr_en;
   tkhq_entry_type  wr_data;

   // derived values
   logic [LW-1:0]   count_ext, cap_ext;
   logic            full;
   logic            csr_wr;
   tkhq_entry_type  req_entry;
   logic [CW-1:0]   pos_slot, par_pos, par_slot, last_slot;
   logic [CW:0]     left_pos, right_pos, count_wide;
   logic            left_ok, right_ok;
   logic            take_left, take_right;
   tkhq_entry_type  cand;

   assign count_ext  = LW'(count_ff);
   assign cap_ext    = LW'(cap_ff);
   assign full       = (count_ext >= cap_ext) || (count_ff >= CW'(DEPTH));
   assign req_entry  = '{severity: req_data.severity, service_time: req_data.service_time,
                         tag: req_data.tag};
   assign pos_slot   = pos_ff - CW'(1);
   assign par_pos    = {1'b0, pos_ff[CW-1:1]};
   assign par_slot   = par_pos - CW'(1);
   assign last_slot  = count_ff - CW'(1);
   assign left_pos   = {pos_ff, 1'b0};
   assign right_pos  = {pos_ff, 1'b1};
   assign count_wide = {1'b0, count_ff};
   assign left_ok    = (left_pos <= count_wide);
   assign right_ok   = (right_pos <= count_wide);

   // child selection for sift down, left wins a full tie
   assign take_left  = outranks(rd_a_ff, move_ff);
   assign cand       = take_left ? rd_a_ff : move_ff;
   assign take_right = right_ok && outranks(rd_b_ff, cand);

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == CSR_CAPACITY);
   assign prdata = (paddr[2] == CSR_CAPACITY) ? {25'd0, cap_ff} : 32'd0;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // state register and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= TKHQ_CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            cap_ff <= pwdata[6:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      move_ff     <= move_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      if (wr_en && (wr_addr == '0)) begin
         top_ff <= wr_data;
      end
   end

   // heap memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   // sequencer: next state, memory accesses and result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      move_in      = move_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rd_a_addr    = '0;
      rd_b_addr    = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = move_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               status_in = STAT_DONE;
               if (req_data.kind == KIND_INSERT) begin
                  if (full) begin
                     status_in = STAT_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     // new entry goes last and climbs
                     count_in = count_ff + CW'(1);
                     pos_in   = count_ff + CW'(1);
                     move_in  = req_entry;
                     state_in = ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                     state_in  = ST_RESP;
                  end else if (count_ff == CW'(1)) begin
                     count_in = '0;
                     state_in = ST_RESP;
                  end else begin
                     // fetch the last entry, it moves to the root
                     count_in  = count_ff - CW'(1);
                     pos_in    = CW'(1);
                     rd_a_addr = last_slot[AW-1:0];
                     state_in  = ST_DN_LAST;
                  end
               end
            end
         end

         ST_UP_RD: begin
            if (pos_ff == CW'(1)) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = move_ff;
               state_in = ST_RESP;
            end else begin
               rd_a_addr = par_slot[AW-1:0];
               state_in  = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            wr_en   = 1'b1;
            wr_addr = pos_slot[AW-1:0];
            if (outranks(move_ff, rd_a_ff)) begin
               // parent moves down, keep climbing
               wr_data  = rd_a_ff;
               pos_in   = par_pos;
               state_in = ST_UP_RD;
            end else begin
               wr_data  = move_ff;
               state_in = ST_RESP;
            end
         end

         ST_DN_LAST: begin
            move_in  = rd_a_ff;
            state_in = ST_DN_RD;
         end

         ST_DN_RD: begin
            if (!left_ok) begin
               wr_en    = 1'b1;
               wr_addr  = pos_slot[AW-1:0];
               wr_data  = move_ff;
               state_in = ST_RESP;
            end else begin
               rd_a_addr = pos_slot[AW-1:0] + pos_ff[AW-1:0];
               if (right_ok) begin
                  rd_b_addr = left_pos[AW-1:0];
               end
               state_in = ST_DN_CMP;
            end
         end

         ST_DN_CMP: begin
            wr_en   = 1'b1;
            wr_addr = pos_slot[AW-1:0];
            if (take_right) begin
               wr_data  = rd_b_ff;
               pos_in   = right_pos[CW-1:0];
               state_in = ST_DN_RD;
            end else if (take_left) begin
               wr_data  = rd_a_ff;
               pos_in   = left_pos[CW-1:0];
               state_in = ST_DN_RD;
            end else begin
               wr_data  = move_ff;
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.status       = status_ff;
            rsp_data_in.is_empty     = (count_ff == '0);
            rsp_data_in.top_severity = (count_ff == '0) ? 8'd0 : top_ff.severity;
            rsp_data_in.top_time     = (count_ff == '0) ? 16'd0 : top_ff.service_time;
            rsp_data_in.top_tag      = (count_ff == '0) ? 16'd0 : top_ff.tag;
            rsp_data_in.entry_count  = count_ext[6:0];
            state_in                 = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
